// File: src/vector_direction_degrees_top_defines.svh
// ----------------------------------------------------------------------------
// Vector direction assertion macros
// Shared concurrent assertion forms for the vector direction block.
// ----------------------------------------------------------------------------
`ifndef VECTOR_DIRECTION_DEGREES_TOP_DEFINES_SVH
`define VECTOR_DIRECTION_DEGREES_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define VDD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define VDD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/vdd_pkg.sv
// ----------------------------------------------------------------------------
// Vector direction package
// Beat types, fixed-point widths and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package vdd_pkg;

    localparam int unsigned CoordBits  = 16;
    localparam int unsigned PreShift   = 58 - CoordBits;
    localparam int unsigned XW         = CoordBits + PreShift + 3;
    localparam int unsigned ZW         = 25;
    localparam int unsigned TableLen   = 24;
    localparam int unsigned AngleBits  = 17;
    localparam int unsigned FqBits     = 15;
    localparam int unsigned ZcBits     = 23;
    localparam int unsigned QuarterZ   = 90 * 65536;
    localparam int unsigned RoundHalf  = 128;
    localparam int unsigned QuarterAng = 90 * 256;
    localparam int unsigned HalfTurn   = 180 * 256;
    localparam int unsigned FullTurn   = 360 * 256;

    typedef struct packed {
        logic signed [CoordBits-1:0] from_x;
        logic signed [CoordBits-1:0] from_y;
        logic signed [CoordBits-1:0] to_x;
        logic signed [CoordBits-1:0] to_y;
    } t_vdd_in;

    typedef struct packed {
        logic [AngleBits-1:0] angle;
        logic                 zero_vector;
    } t_vdd_out;

    typedef enum logic [1:0] {
        QUAD_I,
        QUAD_II,
        QUAD_III,
        QUAD_IV
    } t_quad;

    // Control that rides alongside the rotation data.
    typedef struct packed {
        logic  valid;
        logic  zero_vec;
        logic  fq_zero;
        logic  fq_ninety;
        t_quad quad;
    } t_vdd_ctl;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_vdd_rot;

    // atan(2^-idx) in degrees, 16 fraction bits, rounded to nearest.
    function automatic logic signed [ZW-1:0] atan_step(input int unsigned idx);
        logic signed [ZW-1:0] v;
        case (idx)
            0:       v = ZW'(2949120);
            1:       v = ZW'(1740967);
            2:       v = ZW'(919879);
            3:       v = ZW'(466945);
            4:       v = ZW'(234379);
            5:       v = ZW'(117304);
            6:       v = ZW'(58666);
            7:       v = ZW'(29335);
            8:       v = ZW'(14668);
            9:       v = ZW'(7334);
            10:      v = ZW'(3667);
            11:      v = ZW'(1833);
            12:      v = ZW'(917);
            13:      v = ZW'(458);
            14:      v = ZW'(229);
            15:      v = ZW'(115);
            16:      v = ZW'(57);
            17:      v = ZW'(29);
            18:      v = ZW'(14);
            19:      v = ZW'(7);
            20:      v = ZW'(4);
            21:      v = ZW'(2);
            22:      v = ZW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: src/vdd_cordic_stage.sv
// ----------------------------------------------------------------------------
// Vector direction CORDIC stage
// One registered vectoring micro-rotation with a fixed shift.
// ----------------------------------------------------------------------------
module vdd_cordic_stage #(
    parameter int unsigned STEP = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  vdd_pkg::t_vdd_ctl i_ctl,
    input  vdd_pkg::t_vdd_rot i_rot,
    output vdd_pkg::t_vdd_ctl o_ctl,
    output vdd_pkg::t_vdd_rot o_rot
);
    import vdd_pkg::*;

    logic signed [XW-1:0] x_in;
    logic signed [XW-1:0] y_in;
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    t_vdd_ctl             r_ctl;
    t_vdd_rot             r_rot;
    t_vdd_rot             n_rot;

    assign x_in = i_rot.x;
    assign y_in = i_rot.y;
    assign xs   = x_in >>> STEP;
    assign ys   = y_in >>> STEP;

    // Rotate towards the x axis; y sign picks the direction.
    always_comb begin
        if (!y_in[XW-1]) begin
            n_rot.x = x_in + ys;
            n_rot.y = y_in - xs;
            n_rot.z = i_rot.z + atan_step(STEP);
        end else begin
            n_rot.x = x_in - ys;
            n_rot.y = y_in + xs;
            n_rot.z = i_rot.z - atan_step(STEP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rot <= n_rot;
        end
    end

    assign o_ctl = r_ctl;
    assign o_rot = r_rot;

endmodule

// File: src/vdd_prep.sv
// ----------------------------------------------------------------------------
// Vector direction front end
// Point difference, magnitude, quadrant and CORDIC start values.
// ----------------------------------------------------------------------------
module vdd_prep (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  vdd_pkg::t_vdd_in  i_data,
    output vdd_pkg::t_vdd_ctl o_ctl,
    output vdd_pkg::t_vdd_rot o_rot
);
    import vdd_pkg::*;

    localparam int unsigned XPad = XW - CoordBits - PreShift;

    logic                        r_d_valid;
    logic signed [CoordBits:0]   r_dx;
    logic signed [CoordBits:0]   r_dy;
    logic signed [CoordBits:0]   n_dx;
    logic signed [CoordBits:0]   n_dy;
    logic signed [CoordBits:0]   abs_dx;
    logic signed [CoordBits:0]   abs_dy;
    logic                        neg_x;
    logic                        neg_y;
    logic                        zero_x;
    logic                        zero_y;
    logic                        pos_x;
    logic                        pos_y;
    t_vdd_ctl                    n_ctl;
    t_vdd_ctl                    r_ctl;
    t_vdd_rot                    n_rot;
    t_vdd_rot                    r_rot;

    // Stage 1: sign-extended differences.
    assign n_dx = {i_data.to_x[CoordBits-1], i_data.to_x}
                - {i_data.from_x[CoordBits-1], i_data.from_x};
    assign n_dy = {i_data.to_y[CoordBits-1], i_data.to_y}
                - {i_data.from_y[CoordBits-1], i_data.from_y};

    // Stage 2: magnitudes and quadrant.
    assign neg_x  = r_dx[CoordBits];
    assign neg_y  = r_dy[CoordBits];
    assign zero_x = (r_dx == '0);
    assign zero_y = (r_dy == '0);
    assign pos_x  = !neg_x && !zero_x;
    assign pos_y  = !neg_y && !zero_y;
    assign abs_dx = neg_x ? -r_dx : r_dx;
    assign abs_dy = neg_y ? -r_dy : r_dy;

    always_comb begin
        n_ctl.valid     = r_d_valid;
        n_ctl.zero_vec  = zero_x && zero_y;
        n_ctl.fq_zero   = zero_y;
        n_ctl.fq_ninety = zero_x;
        if (pos_x && !neg_y) begin
            n_ctl.quad = QUAD_I;
        end else if (!pos_x && pos_y) begin
            n_ctl.quad = QUAD_II;
        end else if (neg_x) begin
            n_ctl.quad = QUAD_III;
        end else begin
            n_ctl.quad = QUAD_IV;
        end
        n_rot.x = {{XPad{1'b0}}, abs_dx[CoordBits-1:0], {PreShift{1'b0}}};
        n_rot.y = {{XPad{1'b0}}, abs_dy[CoordBits-1:0], {PreShift{1'b0}}};
        n_rot.z = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
            r_ctl     <= '0;
        end else if (i_en) begin
            r_d_valid <= i_valid;
            r_ctl     <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx  <= n_dx;
            r_dy  <= n_dy;
            r_rot <= n_rot;
        end
    end

    assign o_ctl = r_ctl;
    assign o_rot = r_rot;

endmodule

// File: src/vdd_place.sv
// ----------------------------------------------------------------------------
// Vector direction back end
// Clamp and round the first-quadrant angle, then place it in its quadrant.
// ----------------------------------------------------------------------------
module vdd_place (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  vdd_pkg::t_vdd_ctl i_ctl,
    input  vdd_pkg::t_vdd_rot i_rot,
    output logic              o_valid,
    output vdd_pkg::t_vdd_out o_data
);
    import vdd_pkg::*;

    logic [ZcBits-1:0]    zc;
    logic [ZcBits-1:0]    zr;
    logic [FqBits-1:0]    n_fq;
    logic [FqBits-1:0]    r_fq;
    t_vdd_ctl             r_ctl;
    logic [AngleBits-1:0] fq_ext;
    logic [AngleBits-1:0] placed;
    t_vdd_out             n_out;
    t_vdd_out             r_out;
    logic                 r_out_valid;

    // Stage 1: clamp to [0, 90 deg], round to 1/256 deg, force exact axes.
    always_comb begin
        if (i_rot.z[ZW-1]) begin
            zc = '0;
        end else if (i_rot.z[ZW-2:0] > (ZW-1)'(QuarterZ)) begin
            zc = ZcBits'(QuarterZ);
        end else begin
            zc = i_rot.z[ZcBits-1:0];
        end
        zr = zc + ZcBits'(RoundHalf);
        if (i_ctl.fq_zero) begin
            n_fq = '0;
        end else if (i_ctl.fq_ninety) begin
            n_fq = FqBits'(QuarterAng);
        end else begin
            n_fq = zr[ZcBits-1:8];
        end
    end

    // Stage 2: quadrant placement and wrap of a full turn.
    assign fq_ext = AngleBits'(r_fq);

    always_comb begin
        case (r_ctl.quad)
            QUAD_I:   placed = fq_ext;
            QUAD_II:  placed = AngleBits'(HalfTurn) - fq_ext;
            QUAD_III: placed = AngleBits'(HalfTurn) + fq_ext;
            QUAD_IV:  placed = AngleBits'(FullTurn) - fq_ext;
            default:  placed = fq_ext;
        endcase
        if (placed >= AngleBits'(FullTurn)) begin
            placed = placed - AngleBits'(FullTurn);
        end
        if (r_ctl.zero_vec) begin
            n_out.angle       = '0;
            n_out.zero_vector = 1'b1;
        end else begin
            n_out.angle       = placed;
            n_out.zero_vector = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl       <= '0;
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_ctl       <= i_ctl;
            r_out_valid <= r_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fq  <= n_fq;
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

// File: src/vector_direction_degrees_top.sv
// ----------------------------------------------------------------------------
// Vector direction in degrees
// Pipelined atan2 of the difference between two screen points.
// ----------------------------------------------------------------------------
// Takes a beat of two points (from, to) and returns the direction of the
// vector from -> to in 1/256 degree, measured clockwise from the positive x
// axis with y growing downward, in the range 0 to just under 360 degrees.
// Coincident points give angle 0 with zero_vector set; pure horizontal and
// vertical vectors give exact multiples of 90 degrees. The block accepts one
// beat every clock cycle unless back-pressure freezes the pipeline; each
// result passes through two front-end stages (difference, magnitude and
// quadrant), one register per CORDIC micro-rotation, a clamp-and-round stage
// and the output register. Back-pressure freezes the whole pipeline while
// the output beat is held; a one-beat skid register on the input keeps
// o_stall registered, so an upstream beat offered during a freeze is parked
// and nothing is lost or repeated. Reset is synchronous, active low, and
// clears only the valid bits and control words, not the data registers.
`include "vector_direction_degrees_top_defines.svh"

module vector_direction_degrees_top #(
    parameter int unsigned ANGLE_STEPS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  vdd_pkg::t_vdd_in  i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output vdd_pkg::t_vdd_out o_data
);
    import vdd_pkg::*;

    // Pipeline advance: hold everything while the output beat is refused.
    logic     en;
    // Input skid register.
    logic     r_skid_valid;
    t_vdd_in  r_skid;
    logic     src_valid;
    t_vdd_in  src_data;
    // Stage chain between the front end and the back end.
    t_vdd_ctl chain_ctl [ANGLE_STEPS+1];
    t_vdd_rot chain_rot [ANGLE_STEPS+1];

    assign en      = !(o_valid && i_stall);
    assign o_stall = r_skid_valid;

    // Feed the pipeline from the skid register first, else straight from
    // the port.
    assign src_valid = r_skid_valid || i_valid;
    assign src_data  = r_skid_valid ? r_skid : i_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else if (en) begin
            r_skid_valid <= 1'b0;
        end else if (i_valid && !r_skid_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Park the payload only when a beat arrives during a freeze.
    always_ff @(posedge i_clk) begin
        if (!en && i_valid && !r_skid_valid) begin
            r_skid <= i_data;
        end
    end

    vdd_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (src_valid),
        .i_data  (src_data),
        .o_ctl   (chain_ctl[0]),
        .o_rot   (chain_rot[0])
    );

    // One registered micro-rotation per step.
    for (genvar g = 0; g < ANGLE_STEPS; g++) begin : g_cordic
        vdd_cordic_stage #(
            .STEP (g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (chain_ctl[g]),
            .i_rot   (chain_rot[g]),
            .o_ctl   (chain_ctl[g+1]),
            .o_rot   (chain_rot[g+1])
        );
    end

    vdd_place u_place (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (chain_ctl[ANGLE_STEPS]),
        .i_rot   (chain_rot[ANGLE_STEPS]),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

    // A coincident pair always reports angle 0.
    `VDD_ASSERT_IMP(a_zero_angle, o_valid && o_data.zero_vector, o_data.angle == '0, "zero vector with non-zero angle")
    // The angle never reaches a full turn.
    `VDD_ASSERT_IMP(a_angle_range, o_valid, o_data.angle < AngleBits'(FullTurn), "angle out of range")
    // The skid register fills only while the output beat is refused.
    `VDD_ASSERT_IMP(a_skid_fill, $rose(r_skid_valid), $past(o_valid && i_stall), "skid filled without a freeze")
    // A parked beat is kept for as long as the freeze lasts.
    `VDD_ASSERT_NEXT(a_skid_hold, r_skid_valid && o_valid && i_stall, r_skid_valid && $stable(r_skid), "parked beat lost during freeze")

endmodule
